// ===== sv/imu_complementary_tilt_filter_macros.svh =====
// Assertion helpers for the tilt filter.
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_MACROS_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_MACROS_SVH

`define ICTF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ICTF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/ictf_pkg.sv =====
`timescale 1ns / 1ps
package ictf_pkg;

  localparam int unsigned CordicIterations = 16;
  localparam int unsigned AngleFracBits    = 16;
  localparam int unsigned TabLen           = 24;
  localparam int unsigned Zq               = 24;
  localparam int unsigned VecShift         = 14;
  localparam int unsigned VecW             = 36;
  localparam int unsigned ZW               = 34;
  localparam logic [15:0] AlphaReset       = 16'd64225;
  localparam logic [23:0] FailMax          = 24'hFFFFFF;
  localparam logic [27:0] GyroDiv          = 28'd131000000;

  localparam logic [2:0] RegAlpha = 3'd0;
  localparam logic [2:0] RegAxOff = 3'd1;
  localparam logic [2:0] RegAyOff = 3'd2;
  localparam logic [2:0] RegAzOff = 3'd3;
  localparam logic [2:0] RegGxOff = 3'd4;
  localparam logic [2:0] RegGyOff = 3'd5;

  function automatic logic signed [ZW-1:0] atan_deg(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 34'sd754974720;
      5'd1:  v = 34'sd445687602;
      5'd2:  v = 34'sd235489088;
      5'd3:  v = 34'sd119537938;
      5'd4:  v = 34'sd60000934;
      5'd5:  v = 34'sd30029717;
      5'd6:  v = 34'sd15018523;
      5'd7:  v = 34'sd7509720;
      5'd8:  v = 34'sd3754917;
      5'd9:  v = 34'sd1877466;
      5'd10: v = 34'sd938734;
      5'd11: v = 34'sd469367;
      5'd12: v = 34'sd234684;
      5'd13: v = 34'sd117342;
      5'd14: v = 34'sd58671;
      5'd15: v = 34'sd29335;
      5'd16: v = 34'sd14668;
      5'd17: v = 34'sd7334;
      5'd18: v = 34'sd3667;
      5'd19: v = 34'sd1833;
      5'd20: v = 34'sd917;
      5'd21: v = 34'sd458;
      5'd22: v = 34'sd229;
      5'd23: v = 34'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/ictf_cordic.sv =====
`timescale 1ns / 1ps
module ictf_cordic #(
  parameter int unsigned Iterations = ictf_pkg::CordicIterations
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [ictf_pkg::VecW-1:0] y_i,
  input  logic signed [ictf_pkg::VecW-1:0] x_i,
  output logic                            done_o,
  output logic signed [ictf_pkg::ZW-1:0]  z_o
);
  localparam int unsigned NIt = (Iterations > ictf_pkg::TabLen) ? ictf_pkg::TabLen
                                                                : Iterations;
  localparam logic [4:0] LastIt = 5'(NIt - 1);
  localparam logic signed [ictf_pkg::ZW-1:0] Deg90 = 34'sd1509949440;
  localparam int unsigned W = ictf_pkg::VecW + 2;

  logic signed [W-1:0] x_q, x_d, y_q, y_d;
  logic signed [ictf_pkg::ZW-1:0] z_q, z_d;
  logic [4:0] it_q, it_d;
  logic busy_q, busy_d, done_q, done_d;
  logic signed [W-1:0] xe, ye, dx, dy;

  always_comb begin
    x_d = x_q; y_d = y_q; z_d = z_q; it_d = it_q; busy_d = busy_q; done_d = 1'b0;
    xe = W'(x_i);
    ye = W'(y_i);
    dx = y_q >>> it_q;
    dy = x_q >>> it_q;
    if (start_i) begin
      it_d = '0;
      if (x_i == '0 && y_i == '0) begin
        busy_d = 1'b0; done_d = 1'b1; z_d = '0;
      end else begin
        busy_d = 1'b1;
        if (x_i < 0) begin
          if (y_i >= 0) begin
            x_d = ye; y_d = -xe; z_d = Deg90;
          end else begin
            x_d = -ye; y_d = xe; z_d = -Deg90;
          end
        end else begin
          x_d = xe; y_d = ye; z_d = '0;
        end
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_d = x_q + dx; y_d = y_q - dy; z_d = z_q + ictf_pkg::atan_deg(it_q);
      end else begin
        x_d = x_q - dx; y_d = y_q + dy; z_d = z_q - ictf_pkg::atan_deg(it_q);
      end
      it_d = it_q + 5'd1;
      if (it_q == LastIt) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; it_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; it_q <= it_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
  end

  assign done_o = done_q;
  assign z_o    = z_q;
endmodule

// ===== sv/imu_complementary_tilt_filter.sv =====
`timescale 1ns / 1ps
// Complementary tilt filter: one request yields one result of pitch, roll and
// failure time. A failed read goes straight to the result. For a good read,
// the square root retires one result bit per cycle, the two CORDIC angles
// share one vectoring unit run back to back, each gyro step divides with one
// quotient bit per cycle, and each of the two blends multiplies serially. The
// result is held until taken; the next request is taken in the cycle after
// that.
module imu_complementary_tilt_filter #(
  parameter int unsigned CORDIC_ITERATIONS = ictf_pkg::CordicIterations,
  parameter int unsigned ANGLE_FRAC_BITS   = ictf_pkg::AngleFracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               read_ok_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] gyro_x_i,
  input  logic signed [15:0] gyro_y_i,
  input  logic [15:0]        step_time_us_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [16:0] pitch_angle_o,
  output logic signed [16:0] roll_angle_o,
  output logic [23:0]        fail_time_us_o
);
  localparam int unsigned F   = ANGLE_FRAC_BITS;
  localparam int unsigned ZSh = ictf_pkg::Zq - F;
  localparam int unsigned OSh = F - 8;
  localparam int unsigned NW  = 32 + F;
  localparam logic [5:0]  DivEnd = 6'(NW + 1);
  localparam logic signed [47:0] Lim = 48'sd180 <<< F;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SQRT  = 10'b0000000010,
    S_CROLL = 10'b0000000100,
    S_CPIT  = 10'b0000001000,
    S_GDIVX = 10'b0000010000,
    S_GDIVY = 10'b0000100000,
    S_MUL   = 10'b0001000000,
    S_BLEND = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_WAIT  = 10'b1000000000
  } state_e;

  state_e st_q, st_d;

  logic [15:0] alpha_q, axo_q, ayo_q, azo_q, gxo_q, gyo_q;
  logic signed [31:0] pitch_q, roll_q;
  logic [23:0] fail_q;

  // config
  logic [2:0] ridx;
  assign ridx   = paddr[4:2];
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    case (ridx)
      ictf_pkg::RegAlpha: prdata = {16'd0, alpha_q};
      ictf_pkg::RegAxOff: prdata = {16'd0, axo_q};
      ictf_pkg::RegAyOff: prdata = {16'd0, ayo_q};
      ictf_pkg::RegAzOff: prdata = {16'd0, azo_q};
      ictf_pkg::RegGxOff: prdata = {16'd0, gxo_q};
      ictf_pkg::RegGyOff: prdata = {16'd0, gyo_q};
      default:            prdata = '0;
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ictf_pkg::AlphaReset;
      axo_q <= '0; ayo_q <= '0; azo_q <= '0; gxo_q <= '0; gyo_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        ictf_pkg::RegAlpha: alpha_q <= pwdata[15:0];
        ictf_pkg::RegAxOff: axo_q   <= pwdata[15:0];
        ictf_pkg::RegAyOff: ayo_q   <= pwdata[15:0];
        ictf_pkg::RegAzOff: azo_q   <= pwdata[15:0];
        ictf_pkg::RegGxOff: gxo_q   <= pwdata[15:0];
        ictf_pkg::RegGyOff: gyo_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // datapath registers
  logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q;
  logic [15:0] dt_q;
  logic [63:0] rem_q;     // sqrt operand, 2 bits per cycle
  logic [33:0] srem_q;
  logic [31:0] root_q;
  logic [5:0]  cnt_q;
  logic signed [47:0] aroll_q, apit_q, sgx_q, sgy_q;
  logic [NW-1:0] num_q;   // |p| + div/2, restoring division
  logic [28:0] drem_q;
  logic [NW-1:0] quo_q;
  logic        neg_q;
  logic signed [47:0] mp_q;   // multiplicand g - acc
  logic [16:0]        mr_q;   // multiplier bits
  logic signed [65:0] acc_q;
  logic               phase_q;
  logic               busy_ok_q;

  // cordic
  logic cstart;
  logic signed [ictf_pkg::VecW-1:0] cy, cx;
  logic cdone;
  logic signed [ictf_pkg::ZW-1:0] cz;
  ictf_cordic #(.Iterations(CORDIC_ITERATIONS)) u_cordic (
    .clk_i, .rst_ni, .start_i(cstart), .y_i(cy), .x_i(cx), .done_o(cdone), .z_o(cz)
  );

  logic signed [16:0] axs, ays, azs;
  assign axs = 17'(ax_q); assign ays = 17'(ay_q); assign azs = 17'(az_q);

  // sqrt step: one result bit per cycle
  logic [33:0] trial;
  assign trial = {srem_q[31:0], rem_q[63:62]} - {root_q, 2'b01};

  // division step
  logic [28:0] dsh;
  logic [28:0] dsub;
  assign dsh  = {drem_q[27:0], num_q[NW-1]};
  assign dsub = dsh - {1'b0, ictf_pkg::GyroDiv};

  function automatic logic signed [47:0] rshift(input logic signed [47:0] v,
                                                input int unsigned s);
    logic signed [47:0] h;
    h = (s == 0) ? 48'sd0 : (48'sd1 <<< (s - 1));
    return (v + h) >>> s;
  endfunction

  logic signed [47:0] rnd_z;
  assign rnd_z = rshift(48'(cz), ZSh);

  // gyro product: rate*dt small multiply, registered into num
  logic signed [16:0] rate_m;
  logic signed [33:0] pr;
  logic [33:0]        pmag;
  assign rate_m = (st_q == S_GDIVX) ? 17'(gx_q) : 17'(gy_q);
  assign pr     = rate_m * $signed({1'b0, dt_q});
  assign pmag   = pr[33] ? 34'(-pr) : 34'(pr);

  logic signed [47:0] blend_v, sat_v;
  logic signed [65:0] rounded;
  assign rounded = (acc_q + 66'sd32768) >>> 16;
  assign blend_v = rounded[47:0];
  assign sat_v   = (blend_v > Lim) ? Lim : ((blend_v < -Lim) ? -Lim : blend_v);

  logic signed [47:0] step_sel, st_sel, acc_sel;
  assign step_sel = phase_q ? sgx_q : sgy_q;
  assign st_sel   = phase_q ? 48'(roll_q) : 48'(pitch_q);
  assign acc_sel  = phase_q ? aroll_q : apit_q;

  logic [23:0] fsum_sat;
  logic [24:0] fsum;
  assign fsum     = {1'b0, fail_q} + 25'(step_time_us_i);
  assign fsum_sat = fsum[24] ? ictf_pkg::FailMax : fsum[23:0];

  function automatic logic signed [16:0] oang(input logic signed [31:0] s);
    logic signed [47:0] v;
    v = rshift(48'(s), OSh);
    if (v > 48'sd46080) v = 48'sd46080;
    if (v < -48'sd46080) v = -48'sd46080;
    return v[16:0];
  endfunction

  logic in_acc, out_acc;
  assign in_ready_o = (st_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;

  always_comb begin
    st_d = st_q;
    cstart = 1'b0;
    cy = '0; cx = '0;
    unique case (st_q)
      S_IDLE:  if (in_acc) st_d = read_ok_i ? S_SQRT : S_OUT;
      S_SQRT:  if (cnt_q == 6'd31) begin
        st_d = S_CROLL; cstart = 1'b1;
        cy = ictf_pkg::VecW'(ays) <<< ictf_pkg::VecShift;
        cx = ictf_pkg::VecW'(azs) <<< ictf_pkg::VecShift;
      end
      S_CROLL: if (cdone) begin
        st_d = S_CPIT; cstart = 1'b1;
        cy = ictf_pkg::VecW'(axs) <<< ictf_pkg::VecShift;
        cx = ictf_pkg::VecW'(root_q);
      end
      S_CPIT:  if (cdone) st_d = S_GDIVX;
      S_GDIVX: if (cnt_q == DivEnd) st_d = S_GDIVY;
      S_GDIVY: if (cnt_q == DivEnd) st_d = S_MUL;
      S_MUL:   if (cnt_q == 6'd16) st_d = S_BLEND;
      S_BLEND: st_d = phase_q ? S_OUT : S_MUL;
      S_OUT:   st_d = S_WAIT;
      S_WAIT:  if (out_acc) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; pitch_q <= '0; roll_q <= '0; fail_q <= '0;
      cnt_q <= '0; phase_q <= 1'b0; busy_ok_q <= 1'b0; out_valid_o <= 1'b0;
      pitch_angle_o <= '0; roll_angle_o <= '0; fail_time_us_o <= '0;
    end else begin
      st_q <= st_d;
      if (out_acc) out_valid_o <= 1'b0;
      unique case (st_q)
        S_IDLE: if (in_acc) begin
          cnt_q <= '0; phase_q <= 1'b0; busy_ok_q <= read_ok_i;
          fail_q <= read_ok_i ? 24'd0 : fsum_sat;
        end
        S_SQRT:  cnt_q <= (cnt_q == 6'd31) ? 6'd0 : cnt_q + 6'd1;
        S_CPIT:  cnt_q <= '0;
        S_GDIVX, S_GDIVY: cnt_q <= (cnt_q == DivEnd) ? 6'd0 : cnt_q + 6'd1;
        S_MUL:   cnt_q <= (cnt_q == 6'd16) ? 6'd0 : cnt_q + 6'd1;
        S_BLEND: begin
          if (phase_q) roll_q <= sat_v[31:0];
          else         pitch_q <= sat_v[31:0];
          phase_q <= 1'b1;
          cnt_q   <= '0;
        end
        S_OUT: begin
          out_valid_o <= 1'b1;
          pitch_angle_o <= oang(pitch_q);
          roll_angle_o  <= oang(roll_q);
          fail_time_us_o <= fail_q;
        end
        default: ;
      endcase
    end
  end

  logic signed [15:0] wax, way, waz;
  assign wax = accel_x_i - $signed(axo_q);
  assign way = accel_y_i - $signed(ayo_q);
  assign waz = accel_z_i - $signed(azo_q);

  // payload path
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      S_IDLE: if (in_acc) begin
        ax_q <= wax; ay_q <= way; az_q <= waz;
        gx_q <= gyro_x_i - $signed(gxo_q);
        gy_q <= gyro_y_i - $signed(gyo_q);
        dt_q <= step_time_us_i;
        rem_q <= {2'b0, 32'(way * way) + 32'(waz * waz), 30'd0} >> 2;
        srem_q <= '0; root_q <= '0;
      end
      S_SQRT: begin
        rem_q <= {rem_q[61:0], 2'b00};
        if (!trial[33]) begin
          srem_q <= trial; root_q <= {root_q[30:0], 1'b1};
        end else begin
          srem_q <= {srem_q[31:0], rem_q[63:62]}; root_q <= {root_q[30:0], 1'b0};
        end
      end
      S_CROLL: if (cdone) aroll_q <= rnd_z;
      S_CPIT: if (cdone) apit_q <= rnd_z;
      S_GDIVX, S_GDIVY: begin
        if (cnt_q == 6'd0) begin
          num_q  <= (NW'(pmag) << F) + NW'(ictf_pkg::GyroDiv >> 1);
          neg_q  <= pr[33];
          drem_q <= '0; quo_q <= '0;
        end else if (cnt_q != DivEnd) begin
          num_q <= {num_q[NW-2:0], 1'b0};
          if (!dsub[28]) begin
            drem_q <= dsub; quo_q <= {quo_q[NW-2:0], 1'b1};
          end else begin
            drem_q <= dsh; quo_q <= {quo_q[NW-2:0], 1'b0};
          end
        end else if (st_q == S_GDIVX) begin
          sgx_q <= neg_q ? -48'(quo_q) : 48'(quo_q);
        end else begin
          sgy_q <= neg_q ? -48'(quo_q) : 48'(quo_q);
        end
      end
      S_MUL: begin
        // shift-add alpha*(state+step-acc) on top of acc*65536
        if (cnt_q == 6'd0) begin
          acc_q <= 66'(acc_sel);
          mp_q  <= st_sel + step_sel - acc_sel;
          mr_q  <= {alpha_q, 1'b0};
        end else begin
          acc_q <= mr_q[16] ? (acc_q <<< 1) + 66'(mp_q) : acc_q <<< 1;
          mr_q  <= {mr_q[15:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  `include "imu_complementary_tilt_filter_macros.svh"

  `ICTF_ASSERT_IMPL(a_ready_idle, in_ready_o, !out_valid_o)
  `ICTF_ASSERT_NEXT(a_fail_out, in_acc && !read_ok_i, st_q == S_OUT)
  `ICTF_ASSERT_IMPL(a_ok_clear, out_valid_o && busy_ok_q, fail_time_us_o == 24'd0)
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

  localparam int NumRandom = 500;

  typedef struct {
    logic               read_ok;
    logic signed [15:0] ax, ay, az, gx, gy;
    logic [15:0]        dt;
  } imu_sample_t;

  typedef struct {
    logic signed [16:0] pitch, roll;
    logic [23:0]        fail_us;
  } tilt_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic read_ok_i;
  logic signed [15:0] accel_x_i, accel_y_i, accel_z_i, gyro_x_i, gyro_y_i;
  logic [15:0] step_time_us_i;
  logic signed [16:0] pitch_angle_o, roll_angle_o;
  logic [23:0] fail_time_us_o;

  imu_complementary_tilt_filter i_dut (.*);

  imu_sample_t sample_q[$];
  tilt_t       tilt_q[$];
  int          errors = 0;
  int          hold_off = 0;
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;

  // filter copy
  logic [15:0]        m_alpha;
  logic signed [15:0] m_off[1:5];
  longint             m_pitch, m_roll;
  longint unsigned    m_fail;

  function automatic longint asr_f(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint atan2_deg(longint y, longint x);
    longint z, t, dx, dy;
    int n;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = longint'(90) << ictf_pkg::Zq;
      end else begin
        x = -y; y = t; z = -(longint'(90) << ictf_pkg::Zq);
      end
    end
    n = (ictf_pkg::CordicIterations > ictf_pkg::TabLen) ? ictf_pkg::TabLen
                                                         : ictf_pkg::CordicIterations;
    for (int i = 0; i < n; i++) begin
      dx = asr_f(y, i);
      dy = asr_f(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(ictf_pkg::atan_deg(5'(i)));
      end else begin
        x -= dx; y += dy; z -= longint'(ictf_pkg::atan_deg(5'(i)));
      end
    end
    return z;
  endfunction

  function automatic longint rate_step(longint rate, longint dt);
    longint p, q, m;
    p = rate * dt * (longint'(1) << ictf_pkg::AngleFracBits);
    m = (p < 0) ? -p : p;
    q = (m + 65500000) / 131000000;
    return (p < 0) ? -q : q;
  endfunction

  function automatic longint mix(longint st, longint stp, longint acc);
    longint lim, v;
    lim = longint'(180) << ictf_pkg::AngleFracBits;
    v = longint'(m_alpha) * (st + stp) + (65536 - longint'(m_alpha)) * acc;
    v = (v + 32768) >>> 16;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  function automatic logic signed [16:0] to_out(longint st);
    longint v;
    v = rnd_shift(st, ictf_pkg::AngleFracBits - 8);
    if (v > 46080) v = 46080;
    if (v < -46080) v = -46080;
    return 17'(v);
  endfunction

  function automatic longint off_sub(logic signed [15:0] a, logic signed [15:0] b);
    logic signed [15:0] d;
    d = a - b;
    return longint'(d);
  endfunction

  function automatic tilt_t filter_sample(imu_sample_t s);
    tilt_t r;
    longint ax, ay, az, gx, gy, mag, ar, ap;
    longint unsigned sq;
    if (!s.read_ok) begin
      m_fail += s.dt;
      if (m_fail > 24'hFFFFFF) m_fail = 24'hFFFFFF;
    end else begin
      ax = off_sub(s.ax, m_off[1]);
      ay = off_sub(s.ay, m_off[2]);
      az = off_sub(s.az, m_off[3]);
      gx = off_sub(s.gx, m_off[4]);
      gy = off_sub(s.gy, m_off[5]);
      sq = (longint'(ay * ay) + longint'(az * az)) << (2 * ictf_pkg::VecShift);
      mag = longint'(int_sqrt(sq));
      ar = rnd_shift(atan2_deg(ay << ictf_pkg::VecShift, az << ictf_pkg::VecShift),
                     ictf_pkg::Zq - ictf_pkg::AngleFracBits);
      ap = rnd_shift(atan2_deg(ax << ictf_pkg::VecShift, mag),
                     ictf_pkg::Zq - ictf_pkg::AngleFracBits);
      m_fail = 0;
      m_pitch = mix(m_pitch, rate_step(gy, s.dt), ap);
      m_roll = mix(m_roll, rate_step(gx, s.dt), ar);
    end
    r.pitch = to_out(m_pitch);
    r.roll = to_out(m_roll);
    r.fail_us = 24'(m_fail);
    return r;
  endfunction

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  // handshakes seen at the rising edge
  always @(posedge clk_i) begin
    in_fire  <= rst_ni && in_valid_i && in_ready_o;
    out_fire <= rst_ni && out_valid_o && out_ready_i;
  end

  // driver
  int in_wait = 0;
  always @(negedge clk_i) begin
    imu_sample_t s;
    if (in_fire) begin
      in_valid_i <= 1'b0;
      in_wait = $urandom_range(0, 10);
      if ($urandom_range(0, 2) == 0) in_wait = 0;
    end else if (!in_valid_i) begin
      if (in_wait > 0) begin
        in_wait--;
      end else if (sample_q.size() > 0) begin
        s = sample_q.pop_front();
        tilt_q.push_back(filter_sample(s));
        in_valid_i <= 1'b1;
        read_ok_i <= s.read_ok;
        accel_x_i <= s.ax;
        accel_y_i <= s.ay;
        accel_z_i <= s.az;
        gyro_x_i <= s.gx;
        gyro_y_i <= s.gy;
        step_time_us_i <= s.dt;
      end
    end
  end

  // receiver pacing
  int out_wait = 0;
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off--;
      out_ready_i <= 1'b0;
    end else if (out_fire) begin
      out_wait = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
      out_ready_i <= (out_wait == 0);
    end else if (out_wait > 0) begin
      out_wait--;
      out_ready_i <= (out_wait == 0);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    tilt_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (tilt_q.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = tilt_q.pop_front();
        if (pitch_angle_o !== e.pitch) begin
          $error("pitch_angle exp %0d got %0d", e.pitch, pitch_angle_o);
          errors++;
        end
        if (roll_angle_o !== e.roll) begin
          $error("roll_angle exp %0d got %0d", e.roll, roll_angle_o);
          errors++;
        end
        if (fail_time_us_o !== e.fail_us) begin
          $error("fail_time_us exp %0d got %0d", e.fail_us, fail_time_us_o);
          errors++;
        end
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [15:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == ictf_pkg::RegAlpha) m_alpha = val;
    else m_off[idx] = val;
  endtask

  task automatic drain();
    while (sample_q.size() > 0 || tilt_q.size() > 0 || in_valid_i) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic imu_sample_t rand_sample(bit wild);
    imu_sample_t s;
    s.read_ok = ($urandom_range(0, 5) != 0);
    if (wild) begin
      s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
      s.gx = 16'($urandom); s.gy = 16'($urandom); s.dt = 16'($urandom);
    end else begin
      s.ax = 16'($urandom_range(0, 32000) - 16000);
      s.ay = 16'($urandom_range(0, 32000) - 16000);
      s.az = 16'($urandom_range(0, 32000) - 16000);
      s.gx = 16'($urandom_range(0, 20000) - 10000);
      s.gy = 16'($urandom_range(0, 20000) - 10000);
      s.dt = 16'($urandom_range(500, 20000));
    end
    return s;
  endfunction

  function automatic imu_sample_t mk(logic ok, int ax, int ay, int az, int gx, int gy,
                                     int dt);
    imu_sample_t s;
    s.read_ok = ok; s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az);
    s.gx = 16'(gx); s.gy = 16'(gy); s.dt = 16'(dt);
    return s;
  endfunction

  initial begin
    rst_ni = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid_i = 0; out_ready_i = 0; read_ok_i = 0;
    accel_x_i = 0; accel_y_i = 0; accel_z_i = 0;
    gyro_x_i = 0; gyro_y_i = 0; step_time_us_i = 0;
    m_alpha = ictf_pkg::AlphaReset;
    for (int i = 1; i <= 5; i++) m_off[i] = '0;
    m_pitch = 0; m_roll = 0; m_fail = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    repeat (2) @(posedge clk_i);

    sample_q.push_back(mk(1, 0, 0, 16384, 0, 0, 1000));
    sample_q.push_back(mk(1, 0, 0, 0, 0, 0, 1000));
    sample_q.push_back(mk(1, 0, 0, -16384, 0, 0, 1000));
    sample_q.push_back(mk(1, 32767, 32767, 32767, 32767, 32767, 65535));
    sample_q.push_back(mk(1, -32768, -32768, -32768, -32768, -32768, 65535));
    sample_q.push_back(mk(1, -32768, 0, 0, 32767, -32768, 65535));
    sample_q.push_back(mk(1, 16384, -16384, 0, -32768, 32767, 0));
    sample_q.push_back(mk(0, 1, 2, 3, 4, 5, 65535));
    for (int i = 0; i < 260; i++) sample_q.push_back(mk(0, 0, 0, 0, 0, 0, 65535));
    sample_q.push_back(mk(1, 100, 200, 300, 0, 0, 0));
    for (int i = 0; i < 6; i++)
      sample_q.push_back(mk(1, 0, 0, 16384, 32767, -32768, 65535));
    drain();

    reg_write(ictf_pkg::RegAlpha, 16'd0);
    reg_write(ictf_pkg::RegAxOff, 16'h8000);
    reg_write(ictf_pkg::RegAyOff, 16'h7FFF);
    reg_write(ictf_pkg::RegAzOff, 16'd16384);
    reg_write(ictf_pkg::RegGxOff, 16'h8000);
    reg_write(ictf_pkg::RegGyOff, 16'h7FFF);
    for (int i = 0; i < 20; i++) sample_q.push_back(rand_sample(1));
    hold_off = 2000;
    drain();

    reg_write(ictf_pkg::RegAlpha, 16'hFFFF);
    for (int i = 0; i < 60; i++) sample_q.push_back(rand_sample(i % 3 == 0));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      reg_write(ictf_pkg::RegAlpha, (ph == 0) ? ictf_pkg::AlphaReset : 16'($urandom));
      for (int r = 1; r <= 5; r++) reg_write(3'(r), 16'($urandom_range(0, 600) - 300));
      for (int i = 0; i < NumRandom / 12; i++)
        sample_q.push_back(rand_sample($urandom_range(0, 4) == 0));
      drain();
    end

    if (errors == 0) $display("imu_complementary_tilt_filter test passed");
    else $display("imu_complementary_tilt_filter test failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("imu_complementary_tilt_filter test failed");
    $finish;
  end

endmodule
